[sv/rfts_pkg.sv]
`default_nettype none
package rfts_pkg;
  localparam int MaxBodyDefault = 64;
  localparam int MaxTargetsDefault = 12;

  localparam logic [31:0] HeaderReset = 32'hF4F3F2F1;
  localparam logic [31:0] TailReset = 32'hF8F7F6F5;

  typedef enum logic [2:0] {
    REG_HEADER = 3'd0,
    REG_TAIL = 3'd1,
    REG_MIN_SPEED = 3'd2,
    REG_MIN_QUALITY = 3'd3,
    REG_APPROACH = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    PS_H0, PS_H1, PS_H2, PS_H3, PS_L0, PS_L1, PS_BODY,
    PS_T0, PS_T1, PS_T2, PS_T3, PS_DIV, PS_OUT
  } parse_state_t;

  localparam logic [1:0] StatusTrack = 2'd0;
  localparam logic [1:0] StatusNoTrack = 2'd1;
  localparam logic [1:0] StatusTailBad = 2'd2;

  // handshake between parser and divider
  typedef struct packed {
    logic       start;
    logic [13:0] dividend;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [13:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

[sv/rfts_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle, shared shift/subtract unit.
module rfts_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rfts_pkg::div_req_t req,
  output rfts_pkg::div_rsp_t     rsp
);
  localparam int QW = 14;

  logic [QW-1:0] quo;
  logic [8:0]    rem;
  logic [7:0]    dvs;
  logic [3:0]    cnt;
  logic          busy;
  logic          done_q;
  logic [8:0]    trial;
  logic [9:0]    diff;

  always_comb begin
    trial = {rem[7:0], quo[QW-1]};
    diff = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 4'(QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
        cnt <= cnt - 4'd1;
      end
    end
  end

  // shift one dividend bit in per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[9]) begin
        rem <= diff[8:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  assign rsp = {done_q, quo};

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("start lost");
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("done without work");
endmodule
`default_nettype wire

[sv/radar_frame_target_selector_core.sv]
// Timing: a frame result shows in the cycle after the last tail byte is taken,
// or, when the time to collision is divided out, after the divider's load,
// 14 restoring divide steps and the output register.
// Throughput: one byte per cycle inside a frame; after a frame end the next
// byte waits until the result is taken, and also through the divide if there is one.
// Reset (rst, synchronous, high): header hunt, tracks cleared, registers to defaults.
`default_nettype none
module radar_frame_target_selector_core #(
  parameter int MAX_BODY = rfts_pkg::MaxBodyDefault,
  parameter int MAX_TARGETS = rfts_pkg::MaxTargetsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       frame_status,
  output logic             alarm_bit,
  output logic             is_approaching,
  output logic [7:0]       range_m,
  output logic [7:0]       velocity_kmh,
  output logic signed [7:0] bearing_deg,
  output logic [7:0]       quality,
  output logic             ttc_known,
  output logic [13:0]      ttc_tenths,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [6:0] MaxBody = 7'(MAX_BODY);
  localparam logic [3:0] MaxTgt = 4'(MAX_TARGETS);

  rfts_pkg::parse_state_t state, state_next;
  logic [31:0] header_word, tail_word;
  logic [7:0]  min_speed, min_quality, approach_code;
  logic [7:0]  length_low;
  logic [6:0]  expected_length, bytes_taken;
  logic [3:0]  target_count;
  logic        frame_alarm_flag;
  logic [2:0]  fld;
  logic [3:0]  rec_idx;
  logic [15:0] cur_target;
  logic [32:0] best_track;
  logic [33:0] near_track;
  logic        acc;
  logic [7:0]  hdr_b, tail_b;
  rfts_pkg::div_req_t dreq;
  rfts_pkg::div_rsp_t drsp;

  assign cfg_ready = 1'b1;
  assign acc = in_valid && !in_stall;
  assign in_stall = !(state <= rfts_pkg::PS_T3) || out_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= rfts_pkg::HeaderReset;
      tail_word <= rfts_pkg::TailReset;
      min_speed <= 8'd1;
      min_quality <= 8'd0;
      approach_code <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rfts_pkg::REG_HEADER: header_word <= cfg_data;
        rfts_pkg::REG_TAIL: tail_word <= cfg_data;
        rfts_pkg::REG_MIN_SPEED: min_speed <= cfg_data[7:0];
        rfts_pkg::REG_MIN_QUALITY: min_quality <= cfg_data[7:0];
        rfts_pkg::REG_APPROACH: approach_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state)
      rfts_pkg::PS_H0: hdr_b = header_word[31:24];
      rfts_pkg::PS_H1: hdr_b = header_word[23:16];
      rfts_pkg::PS_H2: hdr_b = header_word[15:8];
      default: hdr_b = header_word[7:0];
    endcase
    unique case (state)
      rfts_pkg::PS_T0: tail_b = tail_word[31:24];
      rfts_pkg::PS_T1: tail_b = tail_word[23:16];
      rfts_pkg::PS_T2: tail_b = tail_word[15:8];
      default: tail_b = tail_word[7:0];
    endcase
  end

  // selection on the final record byte
  logic [7:0] r_ang, r_rng, r_dir, r_spd;
  logic       r_appr, in_rec, near_upd, best_upd;
  logic       body_ok;
  always_comb begin
    r_ang = cur_target[7:0];
    r_rng = cur_target[15:8];
    in_rec = rec_idx < target_count;
    body_ok = (bytes_taken >= 7'd2) &&
      ({1'b0, bytes_taken} >= 8'd2 + 8'(target_count) * 8'd5);
  end

  // record fields: angle, range, direction held; speed arrives at fld 3
  logic [7:0] spd_q;
  logic [7:0] dir_q;
  always_comb begin
    r_dir = dir_q;
    r_spd = spd_q;
    r_appr = r_dir == approach_code;
    near_upd = !near_track[33] || (r_rng < near_track[15:8]);
    best_upd = r_appr && (r_spd >= min_speed) && (rx_byte >= min_quality) &&
      (!best_track[32] || (r_rng < best_track[15:8]));
  end

  logic [31:0] packed_t;
  assign packed_t = {rx_byte, r_spd, r_rng, r_ang};

  // chosen track at frame end
  logic        have, sel_appr, ttc_ok;
  logic [31:0] sel_t;
  always_comb begin
    have = 1'b0; sel_appr = 1'b0; ttc_ok = 1'b0; sel_t = '0;
    if (body_ok) begin
      if (best_track[32]) begin
        have = 1'b1; sel_appr = 1'b1; ttc_ok = 1'b1; sel_t = best_track[31:0];
      end else if (frame_alarm_flag && near_track[33]) begin
        have = 1'b1; sel_appr = near_track[32]; sel_t = near_track[31:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.dividend = 14'(sel_t[15:8]) * 14'd36;
    dreq.divisor = sel_t[23:16];
    unique case (state)
      rfts_pkg::PS_H0, rfts_pkg::PS_H1, rfts_pkg::PS_H2, rfts_pkg::PS_H3:
        if (acc) state_next = (rx_byte == hdr_b) ?
          rfts_pkg::parse_state_t'(state + 4'd1) : rfts_pkg::PS_H0;
      rfts_pkg::PS_L0: if (acc) state_next = rfts_pkg::PS_L1;
      rfts_pkg::PS_L1:
        if (acc) begin
          if (rx_byte != 8'd0 || length_low > 8'(MaxBody))
            state_next = rfts_pkg::PS_H0;
          else if (length_low == 8'd0) state_next = rfts_pkg::PS_T0;
          else state_next = rfts_pkg::PS_BODY;
        end
      rfts_pkg::PS_BODY:
        if (acc && (bytes_taken + 7'd1 >= expected_length))
          state_next = rfts_pkg::PS_T0;
      rfts_pkg::PS_T0, rfts_pkg::PS_T1, rfts_pkg::PS_T2:
        if (acc) state_next = (rx_byte == tail_b) ?
          rfts_pkg::parse_state_t'(state + 4'd1) : rfts_pkg::PS_H0;
      rfts_pkg::PS_T3:
        if (acc) begin
          if (rx_byte == tail_b && have && ttc_ok && sel_t[23:16] != 8'd0) begin
            state_next = rfts_pkg::PS_DIV;
            dreq.start = 1'b1;
          end else state_next = rfts_pkg::PS_H0;
        end
      rfts_pkg::PS_DIV: if (drsp.done) state_next = rfts_pkg::PS_OUT;
      rfts_pkg::PS_OUT: if (!out_stall) state_next = rfts_pkg::PS_H0;
      default: state_next = rfts_pkg::PS_H0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rfts_pkg::PS_H0;
    else state <= state_next;
  end

  // frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      length_low <= '0; expected_length <= '0; bytes_taken <= '0;
      target_count <= '0; frame_alarm_flag <= 1'b0; fld <= '0; rec_idx <= '0;
      cur_target <= '0; spd_q <= '0; dir_q <= '0;
      best_track <= '0; near_track <= '0;
    end else if (acc) begin
      if (state == rfts_pkg::PS_L0) length_low <= rx_byte;
      if (state == rfts_pkg::PS_L1) begin
        bytes_taken <= '0; target_count <= '0; frame_alarm_flag <= 1'b0;
        cur_target <= '0; best_track <= '0; near_track <= '0;
        fld <= '0; rec_idx <= '0;
        expected_length <= (rx_byte != 8'd0 || length_low > 8'(MaxBody)) ?
          7'd0 : length_low[6:0];
      end
      if (state == rfts_pkg::PS_BODY) begin
        bytes_taken <= bytes_taken + 7'd1;
        if (bytes_taken == 7'd0)
          target_count <= (rx_byte > 8'(MaxTgt)) ? MaxTgt : rx_byte[3:0];
        else if (bytes_taken == 7'd1)
          frame_alarm_flag <= rx_byte == 8'd1;
        else begin
          fld <= (fld == 3'd4) ? 3'd0 : fld + 3'd1;
          if (fld == 3'd4 && rec_idx != 4'hF) rec_idx <= rec_idx + 4'd1;
          if (in_rec) begin
            unique case (fld)
              3'd0: cur_target[7:0] <= rx_byte;
              3'd1: cur_target[15:8] <= rx_byte;
              3'd2: dir_q <= rx_byte;
              3'd3: spd_q <= rx_byte;
              default: begin
                if (near_upd) near_track <= {1'b1, r_appr, packed_t};
                if (best_upd) best_track <= {1'b1, packed_t};
              end
            endcase
          end
        end
      end
    end
  end

  rfts_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
    else if (drsp.done) out_valid <= 1'b1;
    else if (acc && state >= rfts_pkg::PS_T0 && state <= rfts_pkg::PS_T3 &&
             (rx_byte != tail_b || state == rfts_pkg::PS_T3) &&
             state_next != rfts_pkg::PS_DIV)
      out_valid <= 1'b1;
  end

  // result fields: tail mismatch, no track, or chosen track; the divider quotient sets the time to collision
  always_ff @(posedge clk) begin
    if (drsp.done) begin
      ttc_known <= 1'b1;
      ttc_tenths <= drsp.quotient;
    end else if (acc && state >= rfts_pkg::PS_T0 && state <= rfts_pkg::PS_T3) begin
      ttc_known <= 1'b0;
      ttc_tenths <= '0;
      if (rx_byte != tail_b) begin
        frame_status <= rfts_pkg::StatusTailBad;
        alarm_bit <= 1'b0; is_approaching <= 1'b0; range_m <= '0;
        velocity_kmh <= '0; bearing_deg <= '0; quality <= '0;
      end else if (!have) begin
        frame_status <= rfts_pkg::StatusNoTrack;
        alarm_bit <= frame_alarm_flag;
        is_approaching <= 1'b0; range_m <= '0; velocity_kmh <= '0;
        bearing_deg <= '0; quality <= '0;
      end else begin
        frame_status <= rfts_pkg::StatusTrack;
        alarm_bit <= frame_alarm_flag;
        is_approaching <= sel_appr;
        range_m <= sel_t[15:8];
        velocity_kmh <= sel_t[23:16];
        bearing_deg <= sel_t[7:0] ^ 8'h80;
        quality <= sel_t[31:24];
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == rfts_pkg::PS_DIV) |-> in_stall) else $error("byte taken while dividing");
  a_div_out: assert property (@(posedge clk) disable iff (rst)
    drsp.done |=> out_valid && ttc_known) else $error("quotient not shown");
  a_best_appr: assert property (@(posedge clk) disable iff (rst)
    (best_track[32] && near_track[33]) |-> near_track[15:8] <= best_track[15:8])
    else $error("near track farther than best");
endmodule
`default_nettype wire

[tb/radar_frame_target_selector_core_checker.sv]
`timescale 1ns / 100ps
module radar_frame_target_selector_core_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  frame_status,
  input  wire logic        alarm_bit,
  input  wire logic        is_approaching,
  input  wire logic [7:0]  range_m,
  input  wire logic [7:0]  velocity_kmh,
  input  wire logic signed [7:0] bearing_deg,
  input  wire logic [7:0]  quality,
  input  wire logic        ttc_known,
  input  wire logic [13:0] ttc_tenths,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending_reports,
  output int               report_total
);
  typedef struct packed {
    logic [1:0]  status;
    logic        alarm;
    logic        appr;
    logic [7:0]  rng;
    logic [7:0]  vel;
    logic [7:0]  bear;
    logic [7:0]  snr;
    logic        tknown;
    logic [13:0] ttc;
  } report_t;

  localparam int MaxBody = rfts_pkg::MaxBodyDefault;
  localparam int MaxTgt = rfts_pkg::MaxTargetsDefault;

  report_t frame_reports[$];

  // predictor copy of configuration and parser state
  logic [31:0] hdr_w, tail_w;
  logic [7:0]  spd_min, snr_min, appr_code;
  rfts_pkg::parse_state_t pst;
  logic [7:0]  len_lo;
  int          body_len, taken, tcount;
  logic        f_alarm;
  logic [31:0] cur;
  logic        best_ok, near_ok, near_appr;
  logic [31:0] best_t, near_t;

  function automatic logic [7:0] word_at(logic [31:0] w, int k);
    return w[31 - 8 * k -: 8];
  endfunction

  task automatic judge(logic [7:0] snr);
    logic [7:0] ang, rng, dir, spd;
    logic [31:0] pk;
    logic ap;
    ang = cur[7:0]; rng = cur[15:8]; dir = cur[23:16]; spd = cur[31:24];
    pk = {snr, spd, rng, ang};
    ap = (dir == appr_code);
    if (!near_ok || rng < near_t[15:8]) begin
      near_t = pk; near_appr = ap; near_ok = 1'b1;
    end
    if (ap && spd >= spd_min && snr >= snr_min)
      if (!best_ok || rng < best_t[15:8]) begin
        best_t = pk; best_ok = 1'b1;
      end
  endtask

  function automatic report_t frame_end();
    report_t r;
    logic [31:0] t;
    logic have, ap, tok;
    r = '0; have = 0; ap = 0; tok = 0; t = '0;
    r.alarm = f_alarm;
    if (taken >= 2 && taken >= 2 + 5 * tcount) begin
      if (best_ok) begin
        t = best_t; have = 1; ap = 1; tok = 1;
      end else if (f_alarm && near_ok) begin
        t = near_t; have = 1; ap = near_appr;
      end
    end
    if (!have) begin
      r.status = rfts_pkg::StatusNoTrack;
      return r;
    end
    r.status = rfts_pkg::StatusTrack;
    r.appr = ap;
    r.rng = t[15:8];
    r.vel = t[23:16];
    r.bear = t[7:0] ^ 8'h80;
    r.snr = t[31:24];
    if (tok && t[23:16] != 0) begin
      r.tknown = 1;
      r.ttc = 14'((36 * int'(t[15:8])) / int'(t[23:16]));
    end
    return r;
  endfunction

  task automatic parse_byte(logic [7:0] b);
    int len, r;
    report_t tr;
    case (pst)
      rfts_pkg::PS_H0, rfts_pkg::PS_H1, rfts_pkg::PS_H2, rfts_pkg::PS_H3: begin
        if (b == word_at(hdr_w, int'(pst) - int'(rfts_pkg::PS_H0)))
          pst = rfts_pkg::parse_state_t'(pst + 1);
        else pst = rfts_pkg::PS_H0;
      end
      rfts_pkg::PS_L0: begin
        len_lo = b; pst = rfts_pkg::PS_L1;
      end
      rfts_pkg::PS_L1: begin
        len = {b, len_lo};
        taken = 0; tcount = 0; f_alarm = 0; cur = '0;
        best_ok = 0; near_ok = 0; near_appr = 0; best_t = '0; near_t = '0;
        if (len > MaxBody) begin
          body_len = 0; pst = rfts_pkg::PS_H0;
        end else begin
          body_len = len; pst = (len == 0) ? rfts_pkg::PS_T0 : rfts_pkg::PS_BODY;
        end
      end
      rfts_pkg::PS_BODY: begin
        if (taken == 0) tcount = (b > MaxTgt) ? MaxTgt : b;
        else if (taken == 1) f_alarm = (b == 8'h01);
        else begin
          r = taken - 2;
          if (r / 5 < tcount) begin
            if (r % 5 < 4) cur[8 * (r % 5) +: 8] = b;
            else judge(b);
          end
        end
        taken = taken + 1;
        if (taken >= body_len) pst = rfts_pkg::PS_T0;
      end
      default: begin
        if (b != word_at(tail_w, int'(pst) - int'(rfts_pkg::PS_T0))) begin
          pst = rfts_pkg::PS_H0;
          tr = '0; tr.status = rfts_pkg::StatusTailBad;
          frame_reports.push_back(tr);
        end else if (pst != rfts_pkg::PS_T3) begin
          pst = rfts_pkg::parse_state_t'(pst + 1);
        end else begin
          pst = rfts_pkg::PS_H0;
          frame_reports.push_back(frame_end());
        end
      end
    endcase
  endtask

  report_t got, want;

  // watch the three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      hdr_w <= rfts_pkg::HeaderReset; tail_w <= rfts_pkg::TailReset;
      spd_min <= 8'd1; snr_min <= 8'd0; appr_code <= 8'd1;
      pst = rfts_pkg::PS_H0; taken = 0; tcount = 0; f_alarm = 0; cur = '0;
      best_ok = 0; near_ok = 0; fail_count <= 0; report_total <= 0;
      frame_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {frame_status, alarm_bit, is_approaching, range_m, velocity_kmh,
               bearing_deg, quality, ttc_known, ttc_tenths};
        report_total <= report_total + 1;
        if (frame_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = frame_reports.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d al=%0d ap=%0d r=%0d v=%0d b=%0d q=%0d tk=%0d t=%0d",
                     $time, want.status, want.alarm, want.appr, want.rng, want.vel,
                     $signed(want.bear), want.snr, want.tknown, want.ttc);
            $display("%0t:          actual   st=%0d al=%0d ap=%0d r=%0d v=%0d b=%0d q=%0d tk=%0d t=%0d",
                     $time, got.status, got.alarm, got.appr, got.rng, got.vel,
                     $signed(got.bear), got.snr, got.tknown, got.ttc);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(rx_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rfts_pkg::REG_HEADER: hdr_w <= cfg_data;
          rfts_pkg::REG_TAIL: tail_w <= cfg_data;
          rfts_pkg::REG_MIN_SPEED: spd_min <= cfg_data[7:0];
          rfts_pkg::REG_MIN_QUALITY: snr_min <= cfg_data[7:0];
          rfts_pkg::REG_APPROACH: appr_code <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending_reports = frame_reports.size();
  end
endmodule

[tb/radar_frame_target_selector_core_tb.sv]
`timescale 1ns / 100ps
module radar_frame_target_selector_core_tb;
  // register index outside the map, must be ignored
  localparam logic [2:0] BadRegIdx = 3'd7;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic [7:0] rx_byte = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_stall, out_valid, cfg_ready, alarm_bit, is_approaching, ttc_known;
  logic [1:0] frame_status;
  logic [7:0] range_m, velocity_kmh, quality;
  logic signed [7:0] bearing_deg;
  logic [13:0] ttc_tenths;
  int fail_count, pending_reports, report_total;

  // current shaping: percent idle per side, long hold-off request
  int send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
  int byte_count = 0;
  logic [31:0] cur_hdr = rfts_pkg::HeaderReset, cur_tail = rfts_pkg::TailReset;
  logic [7:0] cur_appr = 8'd1;

  always #5 clk = ~clk;

  radar_frame_target_selector_core dut (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .frame_status, .alarm_bit, .is_approaching, .range_m, .velocity_kmh,
    .bearing_deg, .quality, .ttc_known, .ttc_tenths, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  radar_frame_target_selector_core_checker chk (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .frame_status, .alarm_bit, .is_approaching, .range_m, .velocity_kmh,
    .bearing_deg, .quality, .ttc_known, .ttc_tenths, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .fail_count, .pending_reports, .report_total
  );

  // receiver stall process, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // valid stays high between back-to-back bytes; it drops on idle or drain
  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    byte_count++;
    @(negedge clk);
  endtask

  task automatic send_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) send_byte(w[31 - 8 * k -: 8]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == rfts_pkg::REG_HEADER) cur_hdr = val;
    if (idx == rfts_pkg::REG_TAIL) cur_tail = val;
    if (idx == rfts_pkg::REG_APPROACH) cur_appr = val[7:0];
  endtask

  // one frame; len_adj changes body length, tail_err breaks a tail byte
  task automatic send_frame(int ntgt, int cnt_byte, int len_adj, int tail_err,
                            logic [7:0] alarm);
    int len;
    logic [7:0] b;
    logic [31:0] t;
    len = 2 + 5 * ntgt + len_adj;
    if (len < 0) len = 0;
    send_word(cur_hdr);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len <= 64) begin
      for (int i = 0; i < len; i++) begin
        if (i == 0) b = cnt_byte[7:0];
        else if (i == 1) b = alarm;
        else if ((i - 2) % 5 == 2 && $urandom_range(2) != 0) b = cur_appr;
        else if ((i - 2) % 5 == 3) b = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        else b = 8'($urandom);
        send_byte(b);
      end
      t = cur_tail;
      if (tail_err >= 0 && tail_err < 4) t[31 - 8 * tail_err -: 8] ^= 8'h01 << $urandom_range(7);
      send_word(t);
    end
  endtask

  task automatic random_frame();
    int n, r;
    n = $urandom_range(4) == 0 ? $urandom_range(12) : $urandom_range(4);
    r = $urandom_range(19);
    if (r == 0) send_frame(n, $urandom, $urandom_range(8), -1, 8'($urandom_range(1)));
    else if (r == 1) send_frame(n, n, -int'($urandom_range(5)), -1, 8'd1);
    else if (r == 2) send_frame(n, n, 0, $urandom_range(3), 8'd1);
    else if (r == 3) repeat ($urandom_range(6)) send_byte(8'($urandom));
    else if (r == 4) send_frame(n, n, 70 + $urandom_range(100), -1, 8'd0);
    else send_frame(n, n, $urandom_range(2) == 0 ? $urandom_range(3) : 0, -1,
                    $urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(1)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: extremes and corner frames at reset settings
    send_frame(0, 0, -2, -1, 8'd0);
    send_frame(1, 1, -3, -1, 8'd1);
    send_frame(12, 12, 0, -1, 8'd1);
    send_frame(12, 255, 0, -1, 8'd0);
    send_frame(2, 2, 3, -1, 8'd1);
    send_frame(2, 2, 0, 0, 8'd1);
    send_frame(2, 2, 0, 3, 8'd0);
    send_frame(1, 1, 63, -1, 8'd0);
    send_byte(8'hF4); send_byte(8'h00); send_byte(8'hFF);
    send_word(cur_hdr); send_byte(8'h02); send_byte(8'h01);
    drain();
    // extreme thresholds
    write_reg(rfts_pkg::REG_MIN_SPEED, 32'd0);
    write_reg(rfts_pkg::REG_MIN_QUALITY, 32'hFF);
    write_reg(rfts_pkg::REG_APPROACH, 32'hFF);
    write_reg(rfts_pkg::REG_HEADER, 32'h0000_0000);
    write_reg(rfts_pkg::REG_TAIL, 32'hFFFF_FFFF);
    write_reg(BadRegIdx, 32'h1234_5678);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 68; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 68; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      if (ph == 2) hold_cycles = 400;
      while (byte_count < 1000 * (ph + 1) / 8 + 250) random_frame();
      // sender waits for all results before reconfiguring
      drain();
      write_reg(rfts_pkg::REG_MIN_SPEED, ph == 7 ? 32'hFF : $urandom_range(40));
      write_reg(rfts_pkg::REG_MIN_QUALITY, ph % 3 == 0 ? 32'd0 : $urandom_range(255));
      write_reg(rfts_pkg::REG_APPROACH, $urandom);
      write_reg(rfts_pkg::REG_HEADER, $urandom);
      write_reg(rfts_pkg::REG_TAIL, ph == 7 ? 32'h0 : $urandom);
    end
    send_frame(3, 3, 0, -1, 8'd1);
    send_idle_pct = 0; stall_pct = 0;
    drain();
    $display("covered %0d bytes, %0d frame results, 8 shaping phases, extreme thresholds",
             byte_count, report_total);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("radar_frame_target_selector_core verification clean");
    end else begin
      $display("radar_frame_target_selector_core verification failed");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #20ms;
    $display("radar_frame_target_selector_core verification failed");
    $finish;
  end
endmodule
